// ===== hw/rtl/pfsb_pkg.sv =====
package pfsb_pkg;

	localparam int PIX_PER_BYTE = 8;

	// Input tdata layout, lowest bit first.
	localparam int SPRITE_LSB   = 0;
	localparam int DEST_COL_LSB = 8;
	localparam int TOP_ROW_LSB  = 18;
	localparam int VALID_LSB    = 28;
	localparam int RD_PAGE_LSB  = 32;
	localparam int RD_COL_LSB   = 35;
	localparam int RD_CLEAR_BIT = 42;

	localparam int S_TDATA_W = 48;
	localparam int S_TUSER_W = 1;
	localparam int M_TDATA_W = 16;

	localparam logic REQ_PLACE = 1'b0;
	localparam logic REQ_READ  = 1'b1;

	typedef enum logic [5:0] {
		ST_CLEAR = 6'b000001,
		ST_IDLE  = 6'b000010,
		ST_RD0   = 6'b000100,
		ST_WR0   = 6'b001000,
		ST_WR1   = 6'b010000,
		ST_OUT   = 6'b100000
	} ctrl_state_t;

	typedef struct packed {
		logic capture;
		logic clr_we;
		logic rd_en;
		logic rd_sel1;
		logic wr0;
		logic wr1;
		logic load_out;
	} ctrl_cmd_t;

	typedef struct packed {
		logic clr_last;
		logic is_read;
		logic out_busy;
	} dp_status_t;

endpackage

// ===== hw/rtl/pfsb_ctrl.sv =====
module pfsb_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  pfsb_pkg::dp_status_t   status,
	output pfsb_pkg::ctrl_cmd_t    cmd
);

	pfsb_pkg::ctrl_state_t state_q;
	pfsb_pkg::ctrl_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pfsb_pkg::ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			pfsb_pkg::ST_CLEAR: begin
				if (status.clr_last) begin
					state_d = pfsb_pkg::ST_IDLE;
				end
			end
			pfsb_pkg::ST_IDLE: begin
				if (in_valid) begin
					state_d = pfsb_pkg::ST_RD0;
				end
			end
			pfsb_pkg::ST_RD0: state_d = pfsb_pkg::ST_WR0;
			pfsb_pkg::ST_WR0: begin
				state_d = status.is_read ? pfsb_pkg::ST_OUT : pfsb_pkg::ST_WR1;
			end
			pfsb_pkg::ST_WR1: state_d = pfsb_pkg::ST_OUT;
			pfsb_pkg::ST_OUT: begin
				if (!status.out_busy) begin
					state_d = pfsb_pkg::ST_IDLE;
				end
			end
			default: state_d = pfsb_pkg::ST_CLEAR;
		endcase
	end

	assign in_ready = (state_q == pfsb_pkg::ST_IDLE);

	always_comb begin
		cmd.capture  = (state_q == pfsb_pkg::ST_IDLE) && in_valid;
		cmd.clr_we   = (state_q == pfsb_pkg::ST_CLEAR);
		// A read request must keep its data word, so the second read is for places only.
		cmd.rd_en    = (state_q == pfsb_pkg::ST_RD0)
			|| ((state_q == pfsb_pkg::ST_WR0) && !status.is_read);
		cmd.rd_sel1  = (state_q == pfsb_pkg::ST_WR0);
		cmd.wr0      = (state_q == pfsb_pkg::ST_WR0);
		cmd.wr1      = (state_q == pfsb_pkg::ST_WR1);
		cmd.load_out = (state_q == pfsb_pkg::ST_OUT) && !status.out_busy;
	end

endmodule

// ===== hw/rtl/pfsb_dp.sv =====
module pfsb_dp #(
	parameter int FRAME_WIDTH  = 128,
	parameter int FRAME_HEIGHT = 64
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic [pfsb_pkg::S_TDATA_W-1:0]     in_data,
	input  logic [pfsb_pkg::S_TUSER_W-1:0]     in_user,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic [pfsb_pkg::M_TDATA_W-1:0]     out_data,
	input  pfsb_pkg::ctrl_cmd_t                cmd,
	output pfsb_pkg::dp_status_t               status
);

	localparam int PAGES = (FRAME_HEIGHT + pfsb_pkg::PIX_PER_BYTE - 1) / pfsb_pkg::PIX_PER_BYTE;
	localparam int DEPTH = FRAME_WIDTH * PAGES;
	localparam int AW    = $clog2(DEPTH);
	localparam int CW    = $clog2(FRAME_WIDTH);
	localparam int PGW   = (PAGES > 1) ? $clog2(PAGES) : 1;

	logic [7:0]    frame_mem_q [DEPTH];
	logic [7:0]    rdata_q;
	logic [AW-1:0] clr_cnt_q;

	logic [AW-1:0] addr0_q;
	logic [AW-1:0] addr1_q;
	logic [7:0]    mask0_q;
	logic [7:0]    data0_q;
	logic [7:0]    mask1_q;
	logic [7:0]    data1_q;
	logic [3:0]    clip_q;
	logic          is_read_q;
	logic          rd_ok_q;

	logic          out_valid_q;
	logic [7:0]    out_rdata_q;
	logic [3:0]    out_clip_q;

	// Request fields.
	logic          req_type;
	logic [7:0]    sprite_byte;
	logic [9:0]    dest_col;
	logic [9:0]    top_row;
	logic [3:0]    valid_bits;
	logic [2:0]    read_page;
	logic [6:0]    read_col;
	logic          read_clear;

	assign req_type    = in_user[0];
	assign sprite_byte = in_data[pfsb_pkg::SPRITE_LSB +: 8];
	assign dest_col    = in_data[pfsb_pkg::DEST_COL_LSB +: 10];
	assign top_row     = in_data[pfsb_pkg::TOP_ROW_LSB +: 10];
	assign valid_bits  = in_data[pfsb_pkg::VALID_LSB +: 4];
	assign read_page   = in_data[pfsb_pkg::RD_PAGE_LSB +: 3];
	assign read_col    = in_data[pfsb_pkg::RD_COL_LSB +: 7];
	assign read_clear  = in_data[pfsb_pkg::RD_CLEAR_BIT];

	logic          col_ok;
	logic [3:0]    cnt;
	logic [7:0]    pix_ok;
	logic [3:0]    clip_cnt;
	logic [15:0]   ok_sh;
	logic [15:0]   spr_sh;
	logic [7:0]    pg0;
	logic [7:0]    pg1;
	logic [AW-1:0] pl_addr0;
	logic [AW-1:0] pl_addr1;
	logic          rd_ok;
	logic [AW-1:0] rd_addr;

	// Each sprite bit lands at row top_row + i; the byte straddles at most two pages.
	always_comb begin
		logic [10:0] row;
		logic        in_cnt;
		col_ok   = !dest_col[9] && ({1'b0, dest_col} < 11'(FRAME_WIDTH));
		cnt      = (valid_bits > 4'(pfsb_pkg::PIX_PER_BYTE)) ? 4'(pfsb_pkg::PIX_PER_BYTE)
			: valid_bits;
		clip_cnt = '0;
		for (int i = 0; i < pfsb_pkg::PIX_PER_BYTE; i++) begin
			row       = {top_row[9], top_row} + 11'(i);
			in_cnt    = (4'(i) < cnt);
			pix_ok[i] = in_cnt && col_ok && !row[10] && (row[9:0] < 10'(FRAME_HEIGHT));
			clip_cnt  = clip_cnt + 4'(in_cnt && !pix_ok[i]);
		end
		ok_sh    = {8'h00, pix_ok} << top_row[2:0];
		spr_sh   = {8'h00, sprite_byte} << top_row[2:0];
		pg0      = {top_row[9], top_row[9:3]};
		pg1      = pg0 + 8'd1;
		pl_addr0 = AW'(AW'(pg0[PGW-1:0]) * AW'(FRAME_WIDTH)) + AW'(dest_col[CW-1:0]);
		pl_addr1 = AW'(AW'(pg1[PGW-1:0]) * AW'(FRAME_WIDTH)) + AW'(dest_col[CW-1:0]);
		rd_ok    = (6'(read_page) < 6'(PAGES)) && (11'(read_col) < 11'(FRAME_WIDTH));
		rd_addr  = AW'(AW'(PGW'(read_page)) * AW'(FRAME_WIDTH)) + AW'(CW'(read_col));
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			is_read_q <= (req_type == pfsb_pkg::REQ_READ);
			rd_ok_q   <= rd_ok;
			if (req_type == pfsb_pkg::REQ_READ) begin
				addr0_q <= rd_addr;
				addr1_q <= rd_addr;
				mask0_q <= (rd_ok && read_clear) ? 8'hFF : 8'h00;
				data0_q <= 8'h00;
				mask1_q <= 8'h00;
				data1_q <= 8'h00;
				clip_q  <= 4'd0;
			end else begin
				addr0_q <= pl_addr0;
				addr1_q <= pl_addr1;
				mask0_q <= ok_sh[7:0];
				data0_q <= spr_sh[7:0];
				mask1_q <= ok_sh[15:8];
				data1_q <= spr_sh[15:8];
				clip_q  <= clip_cnt;
			end
		end
	end

	logic          we;
	logic [AW-1:0] waddr;
	logic [7:0]    wdata;
	logic [7:0]    wmask;
	logic [7:0]    wbits;

	always_comb begin
		wmask = cmd.wr1 ? mask1_q : mask0_q;
		wbits = cmd.wr1 ? data1_q : data0_q;
		we    = cmd.clr_we || (cmd.wr0 && (mask0_q != 8'h00))
			|| (cmd.wr1 && (mask1_q != 8'h00));
		if (cmd.clr_we) begin
			waddr = clr_cnt_q;
			wdata = 8'h00;
		end else begin
			waddr = cmd.wr1 ? addr1_q : addr0_q;
			wdata = (rdata_q & ~wmask) | (wbits & wmask);
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			frame_mem_q[waddr] <= wdata;
		end
		if (cmd.rd_en) begin
			rdata_q <= frame_mem_q[cmd.rd_sel1 ? addr1_q : addr0_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_cnt_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.clr_we) begin
				clr_cnt_q <= clr_cnt_q + AW'(1);
			end
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_rdata_q <= (is_read_q && rd_ok_q) ? rdata_q : 8'h00;
			out_clip_q  <= clip_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = {4'h0, out_clip_q, out_rdata_q};

	assign status.clr_last = (clr_cnt_q == AW'(DEPTH - 1));
	assign status.is_read  = is_read_q;
	assign status.out_busy = out_valid_q && !out_ready;

endmodule

// ===== hw/rtl/page_framebuffer_sprite_blit_unit.sv =====
// Monochrome page frame store of FRAME_WIDTH by FRAME_HEIGHT pixels, eight vertical pixels
// to a byte with bit 0 on top, plus a sprite-byte blitter. After reset the store is swept
// to zero, one byte a cycle, through all FRAME_WIDTH * ceil(FRAME_HEIGHT / 8) bytes (1024 with
// the default size); no request is taken during the sweep. A place request then passes
// through states RD0, WR0, WR1 and OUT before the next acceptance, and a read request skips
// WR1; OUT waits while an older result is still untaken. A sprite byte may straddle two
// pages, so a place performs two read-modify-write passes through the store's single read
// and single write port, each with a registered read. A finished result sits in an output
// register, and the next request is accepted while it waits to be taken.
module page_framebuffer_sprite_blit_unit #(
	parameter int FRAME_WIDTH  = 128,
	parameter int FRAME_HEIGHT = 64
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_axis_tvalid,
	output logic                               s_axis_tready,
	// sprite_byte, dest_col, top_row, valid_bits, read_page, read_col, read_clear, zero pad
	input  logic [pfsb_pkg::S_TDATA_W-1:0]     s_axis_tdata,
	// req_type
	input  logic [pfsb_pkg::S_TUSER_W-1:0]     s_axis_tuser,
	output logic                               m_axis_tvalid,
	input  logic                               m_axis_tready,
	// read_data, clipped_bits, zero pad
	output logic [pfsb_pkg::M_TDATA_W-1:0]     m_axis_tdata
);

	pfsb_pkg::ctrl_cmd_t  cmd;
	pfsb_pkg::dp_status_t status;

	pfsb_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.status   (status),
		.cmd      (cmd)
	);

	pfsb_dp #(
		.FRAME_WIDTH  (FRAME_WIDTH),
		.FRAME_HEIGHT (FRAME_HEIGHT)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_data   (s_axis_tdata),
		.in_user   (s_axis_tuser),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_data  (m_axis_tdata),
		.cmd       (cmd),
		.status    (status)
	);

endmodule
